/* rtl/core/twpc_pkg.sv */
`default_nettype none

package twpc_pkg;

    // mask geometry
    localparam int STATIONS    = 1024;
    localparam int WORD_BITS   = 32;
    localparam int WORDS       = STATIONS / WORD_BITS;
    localparam int IDX_W       = $clog2(WORDS);
    localparam int LEAF_LEVEL  = $clog2(STATIONS);
    localparam int WORD_LEVEL  = $clog2(WORDS);

    // one class tree serves both the in-word walk and the walk over word roots
    localparam int TREE_LEAVES = WORD_BITS;
    localparam int TREE_NODES  = 2 * TREE_LEAVES;
    localparam int CNT_W       = $clog2(TREE_NODES);

    // field widths
    localparam int LVL_W       = 4;
    localparam int TALLY_W     = 11;
    localparam int COLL_W      = 10;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic scan;
        logic top;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/tree_walk_probe_counter_core.sv */
// tree walk probe counter
// input channel: i_in_valid / o_in_stall carry one 32-bit word of the station
// ready mask per beat (i_ready_word) plus i_last_word. words fill slots 0..31
// in order; a beat with i_last_word set closes the mask and starts the walk.
// config: i_cfg_we / i_cfg_data write the start level (0 root .. 10 stations,
// larger values act as 10); write it only while no walk is running.
// output channel: o_out_valid / i_out_stall carry one beat per last word with
// the idle, success, collision and total probe counts.
// throughput: plain mask words are taken one per cycle. the walk reads one
// store word per cycle through a two-stage class tree, then one pass over the
// 32 word roots; o_in_stall stays high from the last-word beat until the
// result is published.
// a stalled result waits in the output register; the next mask may load
// meanwhile, and the following walk holds before publishing until it drains.
// reset (synchronous, active low) empties the output register, sets the word
// slot to 0 and the start level to 0; the mask store is not cleared.
`default_nettype none

module tree_walk_probe_counter_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [twpc_pkg::WORD_BITS-1:0]    i_ready_word,
    input  wire logic                              i_last_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [twpc_pkg::LVL_W-1:0]        i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [twpc_pkg::TALLY_W-1:0]           o_idle_count,
    output logic [twpc_pkg::TALLY_W-1:0]           o_success_count,
    output logic [twpc_pkg::COLL_W-1:0]            o_collision_count,
    output logic [twpc_pkg::TALLY_W-1:0]           o_probe_count
);

    twpc_pkg::t_cmd w_cmd;
    twpc_pkg::t_sts w_sts;

    // walk sequencing
    twpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_word (i_last_word),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // store, class tree and tallies
    twpc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_ready_word      (i_ready_word),
        .i_last_word       (i_last_word),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_idle_count      (o_idle_count),
        .o_success_count   (o_success_count),
        .o_collision_count (o_collision_count),
        .o_probe_count     (o_probe_count)
    );

endmodule

`default_nettype wire

/* rtl/core/twpc_ctrl.sv */
`default_nettype none

module twpc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_last_word,
    output logic                 o_in_stall,
    input  wire twpc_pkg::t_sts  i_sts,
    output twpc_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_TOP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last_word) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                o_cmd.top = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.pipe_busy && i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // words are taken only between walks
    assign o_in_stall = (r_state != S_LOAD);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/twpc_dp.sv */
`default_nettype none

module twpc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire twpc_pkg::t_cmd                    i_cmd,
    output twpc_pkg::t_sts                         o_sts,
    input  wire logic [twpc_pkg::WORD_BITS-1:0]    i_ready_word,
    input  wire logic                              i_last_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [twpc_pkg::LVL_W-1:0]        i_cfg_data,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic [twpc_pkg::TALLY_W-1:0]           o_idle_count,
    output logic [twpc_pkg::TALLY_W-1:0]           o_success_count,
    output logic [twpc_pkg::COLL_W-1:0]            o_collision_count,
    output logic [twpc_pkg::TALLY_W-1:0]           o_probe_count
);

    localparam int WB    = twpc_pkg::WORD_BITS;
    localparam int NW    = twpc_pkg::WORDS;
    localparam int IW    = twpc_pkg::IDX_W;
    localparam int LV    = twpc_pkg::LVL_W;
    localparam int TW    = twpc_pkg::TALLY_W;
    localparam int CW    = twpc_pkg::CNT_W;
    localparam int NL    = twpc_pkg::TREE_LEAVES;
    localparam int NN    = twpc_pkg::TREE_NODES;

    // occupancy class of a subtree
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_MANY
    } t_cls;

    function automatic t_cls cls_merge(input t_cls a, input t_cls b);
        t_cls m;
        if (a == CLS_ZERO) begin
            m = b;
        end else if (b == CLS_ZERO) begin
            m = a;
        end else begin
            m = CLS_MANY;
        end
        return m;
    endfunction

    // depth of heap node n below the tree root
    function automatic int node_depth(input int n);
        int d;
        d = 0;
        for (int k = 1; k < 8; k++) begin
            if ((n >> k) != 0) begin
                d = k;
            end
        end
        return d;
    endfunction

    function automatic logic [CW-1:0] popcnt(input logic [NN-1:1] v);
        logic [CW-1:0] c;
        c = '0;
        for (int i = 1; i < NN; i++) begin
            c = c + CW'(v[i]);
        end
        return c;
    endfunction

    // ready mask store
    logic [WB-1:0] r_store [NW];
    logic [WB-1:0] r_rd_data;

    logic [IW-1:0] r_word_idx;
    logic [IW-1:0] r_scan_idx;
    logic [LV-1:0] r_start_level;

    // stage one: word read out (or word-root pass), stage two: probe flags
    logic          r_s1_v;
    logic          r_s1_top;
    logic [IW-1:0] r_s1_k;
    logic          r_s2_v;
    t_cls          r_word_cls [NL];

    logic [NN-1:1] r_f_idle;
    logic [NN-1:1] r_f_succ;
    logic [NN-1:1] r_f_coll;

    logic [TW-1:0] r_tally_idle;
    logic [TW-1:0] r_tally_succ;
    logic [TW-1:0] r_tally_coll;

    logic          r_out_valid;
    logic [TW-1:0] r_out_idle;
    logic [TW-1:0] r_out_succ;
    logic [TW-1:0] r_out_coll;
    logic [TW-1:0] r_out_probe;

    t_cls          cls [1:NN-1];
    logic [NN-1:1] n_f_idle;
    logic [NN-1:1] n_f_succ;
    logic [NN-1:1] n_f_coll;
    logic [LV-1:0] start_sat;
    logic [LV-1:0] base_lvl;

    // status back to the controller
    assign o_sts.scan_last = (r_scan_idx == IW'(NW - 1));
    assign o_sts.pipe_busy = r_s1_v | r_s2_v;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // start level saturates at the station level
    assign start_sat = (r_start_level > LV'(twpc_pkg::LEAF_LEVEL)) ?
                       LV'(twpc_pkg::LEAF_LEVEL) : r_start_level;
    assign base_lvl  = r_s1_top ? '0 : LV'(twpc_pkg::WORD_LEVEL);

    // memory write on load beats, read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_store[r_word_idx] <= i_ready_word;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_store[r_scan_idx];
        end
    end

    // class tree over 32 leaves
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (r_s1_top) begin
                cls[NL + i] = r_word_cls[i];
            end else begin
                cls[NL + i] = r_rd_data[i] ? CLS_ONE : CLS_ZERO;
            end
        end
        for (int i = NL - 1; i >= 1; i--) begin
            cls[i] = cls_merge(cls[2 * i], cls[2 * i + 1]);
        end
    end

    // probe flags; the word root is counted in the word-root pass only
    always_comb begin
        for (int i = 1; i < NN; i++) begin
            logic [LV-1:0] lvl;
            logic          counted;
            logic          at_start;
            logic          below;
            logic          parent_many;
            lvl         = base_lvl + LV'(node_depth(i));
            counted     = r_s1_top || (i != 1);
            at_start    = (lvl == start_sat);
            below       = (lvl > start_sat);
            parent_many = (i >= 2) && (cls[i >> 1] == CLS_MANY);
            n_f_idle[i] = counted && at_start && (cls[i] == CLS_ZERO);
            n_f_succ[i] = counted && (at_start || (below && parent_many)) &&
                          (cls[i] == CLS_ONE);
            n_f_coll[i] = counted && (at_start || below) && (cls[i] == CLS_MANY);
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan || i_cmd.top) begin
            r_s1_top <= i_cmd.top;
            r_s1_k   <= r_scan_idx;
        end
        if (r_s1_v) begin
            r_f_idle <= n_f_idle;
            r_f_succ <= n_f_succ;
            r_f_coll <= n_f_coll;
        end
        if (r_s1_v && !r_s1_top) begin
            r_word_cls[r_s1_k] <= cls[1];
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_idle  <= r_tally_idle;
            r_out_succ  <= r_tally_succ;
            r_out_coll  <= r_tally_coll;
            r_out_probe <= r_tally_idle + r_tally_succ + r_tally_coll;
        end
    end

    // control registers and tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_idx    <= '0;
            r_scan_idx    <= '0;
            r_start_level <= '0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_tally_idle  <= '0;
            r_tally_succ  <= '0;
            r_tally_coll  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_level <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_word_idx <= i_last_word ? '0 : r_word_idx + 1'b1;
            end
            if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            r_s1_v <= i_cmd.scan | i_cmd.top;
            r_s2_v <= r_s1_v;
            if (i_cmd.clr) begin
                r_tally_idle <= '0;
                r_tally_succ <= '0;
                r_tally_coll <= '0;
            end else if (r_s2_v) begin
                r_tally_idle <= r_tally_idle + TW'(popcnt(r_f_idle));
                r_tally_succ <= r_tally_succ + TW'(popcnt(r_f_succ));
                r_tally_coll <= r_tally_coll + TW'(popcnt(r_f_coll));
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_idle_count      = r_out_idle;
    assign o_success_count   = r_out_succ;
    assign o_collision_count = r_out_coll[twpc_pkg::COLL_W-1:0];
    assign o_probe_count     = r_out_probe;

`ifndef SYNTH
    // tallies are published only once the pipeline has drained
    a_publish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> (!r_s1_v && !r_s2_v))
        else $error("publish while walk pipeline busy");

    // a pending result is never overwritten
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> !(r_out_valid && i_out_stall))
        else $error("publish over a stalled result");

    // no word lands in the store while a walk is in flight
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_s1_v && !r_s2_v && !i_cmd.scan))
        else $error("load beat during walk");

    // the word-root pass follows the last word read
    a_scan_to_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && o_sts.scan_last) |=> i_cmd.top)
        else $error("word-root pass missing after scan");

    // at most 1023 collisions in a tree of 1024 stations
    a_coll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally_coll[twpc_pkg::COLL_W] == 1'b0)
        else $error("collision tally out of range");
`endif

endmodule

`default_nettype wire
